[hdl/pshc_pkg.sv]
`default_nettype none
package pshc_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int TABLE_LEN    = 20;

    // datapath widths
    localparam int IN_W  = 16;
    localparam int HD_W  = 15;
    localparam int XW    = 24;
    localparam int ZW    = 20;
    localparam int EW    = 21;
    localparam int WE_W  = 19;
    localparam int DST_W = 18;
    localparam int LIN_W = 18;
    localparam int ANG_W = 19;
    localparam int GN_W  = 12;

    localparam logic signed [ZW-1:0] ANG_PI_Z = 20'sd205887;
    localparam logic signed [EW-1:0] ANG_PI     = 21'sd205887;
    localparam logic signed [EW-1:0] ANG_TWO_PI = 21'sd411775;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic [16:0] ATAN_TAB [TABLE_LEN] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
        17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
        17'd1, 17'd0, 17'd0, 17'd0
    };

    typedef enum logic [1:0] {
        CFG_STOP_DIST = 2'd0,
        CFG_LIN_GAIN  = 2'd1,
        CFG_ANG_GAIN  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic signed [HD_W-1:0] heading;
    } t_tag;

    typedef struct packed {
        logic [IN_W-1:0] stop_distance;
        logic [GN_W-1:0] linear_gain;
        logic [GN_W-1:0] angular_gain;
    } t_cfg;

    function automatic logic signed [EW-1:0] wrap_once(input logic signed [EW-1:0] a);
        logic signed [EW-1:0] r;
        r = a;
        if (a > ANG_PI) begin
            r = a - ANG_TWO_PI;
        end else if (a < -ANG_PI) begin
            r = a + ANG_TWO_PI;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/pshc_prep.sv]
`default_nettype none
module pshc_prep
    import pshc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [IN_W-1:0]        i_leader_x,
    input  wire logic [IN_W-1:0]        i_leader_y,
    input  wire logic [IN_W-1:0]        i_follower_x,
    input  wire logic [IN_W-1:0]        i_follower_y,
    input  wire logic signed [HD_W-1:0] i_follower_heading,
    output t_vec                        o_vec,
    output t_tag                        o_tag
);

    logic signed [IN_W:0]  w_dx;
    logic signed [IN_W:0]  w_dy;
    logic signed [XW-1:0]  w_x;
    logic signed [XW-1:0]  w_y;
    t_vec                  n_vec;
    t_vec                  r_vec;
    t_tag                  r_tag;

    always_comb begin
        w_dx = $signed({1'b0, i_leader_x}) - $signed({1'b0, i_follower_x});
        w_dy = $signed({1'b0, i_leader_y}) - $signed({1'b0, i_follower_y});
        // four guard bits below the q.12 point
        w_x  = $signed({{(XW-IN_W-5){w_dx[IN_W]}}, w_dx, 4'b0000});
        w_y  = $signed({{(XW-IN_W-5){w_dy[IN_W]}}, w_dy, 4'b0000});
        n_vec.x = w_x;
        n_vec.y = w_y;
        n_vec.z = '0;
        // left half plane: rotate by pi first
        if (w_dx < 0) begin
            n_vec.x = -w_x;
            n_vec.y = -w_y;
            n_vec.z = (w_dy >= 0) ? ANG_PI_Z : -ANG_PI_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag.valid <= i_valid;
        end
        if (i_en) begin
            r_vec         <= n_vec;
            r_tag.zero    <= (w_dx == 0) && (w_dy == 0);
            r_tag.heading <= i_follower_heading;
        end
    end

    assign o_vec = r_vec;
    assign o_tag = r_tag;

endmodule
`default_nettype wire

[hdl/pshc_cordic.sv]
`default_nettype none
module pshc_cordic
    import pshc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_vec      i_vec,
    input  t_tag      i_tag,
    output t_vec      o_vec,
    output t_tag      o_tag
);

    t_vec w_vec [CORDIC_STEPS+1];
    t_tag w_tag [CORDIC_STEPS+1];

    assign w_vec[0] = i_vec;
    assign w_tag[0] = i_tag;

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [ZW-1:0] w_at;
        t_vec                 n_vec;
        t_vec                 r_vec;
        t_tag                 r_tag;

        always_comb begin
            w_xs = w_vec[s].x >>> s;
            w_ys = w_vec[s].y >>> s;
            w_at = $signed({{(ZW-17){1'b0}}, ATAN_TAB[s]});
            if (w_vec[s].y >= 0) begin
                n_vec.x = w_vec[s].x + w_ys;
                n_vec.y = w_vec[s].y - w_xs;
                n_vec.z = w_vec[s].z + w_at;
            end else begin
                n_vec.x = w_vec[s].x - w_ys;
                n_vec.y = w_vec[s].y + w_xs;
                n_vec.z = w_vec[s].z - w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag.valid <= 1'b0;
            end else if (i_en) begin
                r_tag.valid <= w_tag[s].valid;
            end
            if (i_en) begin
                r_vec         <= n_vec;
                r_tag.zero    <= w_tag[s].zero;
                r_tag.heading <= w_tag[s].heading;
            end
        end

        assign w_vec[s+1] = r_vec;
        assign w_tag[s+1] = r_tag;
    end

    assign o_vec = w_vec[CORDIC_STEPS];
    assign o_tag = w_tag[CORDIC_STEPS];

endmodule
`default_nettype wire

[hdl/pshc_post.sv]
`default_nettype none
module pshc_post
    import pshc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  t_vec                   i_vec,
    input  t_tag                   i_tag,
    input  t_cfg                   i_cfg,
    output logic                   o_valid,
    output logic [LIN_W-1:0]       o_linear_speed,
    output logic signed [ANG_W-1:0] o_angular_rate
);

    localparam int PW  = XW + 17;
    localparam int LPW = DST_W + GN_W;
    localparam int APW = WE_W + GN_W + 1;

    // stage 1: gain compensation product, raw heading error
    logic                    r_s1_valid;
    logic                    r_s1_zero;
    logic signed [PW-1:0]    r_s1_prod;
    logic signed [EW-1:0]    r_s1_err;

    // stage 2: rounded distance, wrapped error
    logic                    r_s2_valid;
    logic [DST_W-1:0]        r_s2_dist;
    logic signed [WE_W-1:0]  r_s2_err;

    // stage 3: gain products, stop-distance comparison
    logic                    r_s3_valid;
    logic                    r_s3_over;
    logic [LPW-1:0]          r_s3_lprod;
    logic signed [APW-1:0]   r_s3_aprod;

    logic                    r_out_valid;
    logic [LIN_W-1:0]        r_lin;
    logic signed [ANG_W-1:0] r_ang;

    logic signed [PW-1:0]    w_rnd;
    logic signed [PW-21:0]   w_dist_full;
    logic [DST_W-1:0]        n_dist;
    logic signed [EW-1:0]    w_wrap1;
    logic signed [EW-1:0]    w_wrap2;
    logic [LPW:0]            w_lsum;
    logic [LPW-8:0]          w_lsh;
    logic [LIN_W-1:0]        n_lin;
    logic signed [APW:0]     w_asum;
    logic signed [APW-12:0]  w_ash;
    logic signed [ANG_W-1:0] n_ang;

    always_comb begin
        w_rnd       = r_s1_prod + $signed({{(PW-20){1'b0}}, 20'h80000});
        w_dist_full = w_rnd[PW-1:20];
        if (r_s1_zero || w_dist_full < 0) begin
            n_dist = '0;
        end else begin
            n_dist = w_dist_full[DST_W-1:0];
        end
        w_wrap1 = wrap_once(r_s1_err);
        w_wrap2 = wrap_once(w_wrap1);
    end

    always_comb begin
        w_lsum = {1'b0, r_s3_lprod} + (LPW+1)'(128);
        w_lsh  = w_lsum[LPW:8];
        if (!r_s3_over) begin
            n_lin = '0;
        end else if (w_lsh > (LPW-7)'(2**LIN_W - 1)) begin
            n_lin = '1;
        end else begin
            n_lin = w_lsh[LIN_W-1:0];
        end
        w_asum = {r_s3_aprod[APW-1], r_s3_aprod} + (APW+1)'(2048);
        w_ash  = w_asum[APW:12];
        if (w_ash > (APW-11)'(2**(ANG_W-1) - 1)) begin
            n_ang = {1'b0, {(ANG_W-1){1'b1}}};
        end else if (w_ash < -(APW-11)'(2**(ANG_W-1))) begin
            n_ang = {1'b1, {(ANG_W-1){1'b0}}};
        end else begin
            n_ang = w_ash[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid  <= i_tag.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_zero  <= i_tag.zero;
            r_s1_prod  <= i_vec.x * $signed({1'b0, INV_GAIN});
            // zero offset has bearing zero, whatever the cordic accumulated
            r_s1_err   <= (i_tag.zero ? EW'(0) : EW'(i_vec.z))
                          - EW'($signed({i_tag.heading, 4'b0000}));
            r_s2_dist  <= n_dist;
            r_s2_err   <= w_wrap2[WE_W-1:0];
            r_s3_over  <= r_s2_dist > DST_W'(i_cfg.stop_distance);
            r_s3_lprod <= r_s2_dist * i_cfg.linear_gain;
            r_s3_aprod <= r_s2_err * $signed({1'b0, i_cfg.angular_gain});
            r_lin      <= n_lin;
            r_ang      <= n_ang;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_linear_speed = r_lin;
    assign o_angular_rate = r_ang;

    a_err_wrapped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_err <= WE_W'(ANG_PI) && r_s2_err >= -WE_W'(ANG_PI)))
        else $error("heading error left the -pi..pi range");

    a_zero_dist : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_s1_valid && r_s1_zero) |=> (r_s2_dist == '0))
        else $error("zero offset gave a non-zero distance");

    a_stop_speed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_s3_valid && !r_s3_over) |=> (o_linear_speed == '0))
        else $error("speed not zero inside the stop distance");

endmodule
`default_nettype wire

[hdl/pursuit_speed_heading_control_top.sv]
// pursuit speed and heading controller
//
// input channel (i_valid / o_ready): one transaction carries the leader
// position and the follower pose of one control tick. output channel
// (o_valid / i_ready): one transaction per input, with the linear speed
// and angular rate commands, in input order.
// configuration: i_cfg_we writes i_cfg_data into the register selected by
// i_cfg_idx (0 stop distance, 1 linear gain, 2 angular gain, 3 ignored);
// write only while the pipeline is empty.
// from input transaction to o_valid the pipeline has one stage for
// the offset and half-plane pre-rotation, one stage per cordic iteration
// (14), and four stages for gain correction, error wrap, gain products
// and saturation. throughput is one transaction per cycle while the
// receiver takes results; the unrolled cordic sets the depth.
// reset clears all stage valid bits and loads the default gains.
// when the receiver stalls with a result waiting, the whole pipeline
// holds and o_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module pursuit_speed_heading_control_top
    import pshc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [IN_W-1:0]         i_leader_x,
    input  wire logic [IN_W-1:0]         i_leader_y,
    input  wire logic [IN_W-1:0]         i_follower_x,
    input  wire logic [IN_W-1:0]         i_follower_y,
    input  wire logic signed [HD_W-1:0]  i_follower_heading,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [LIN_W-1:0]             o_linear_speed,
    output logic signed [ANG_W-1:0]      o_angular_rate,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [IN_W-1:0]         i_cfg_data
);

    t_cfg r_cfg;
    logic w_en;
    logic w_out_valid;
    t_vec w_prep_vec;
    t_tag w_prep_tag;
    t_vec w_cor_vec;
    t_tag w_cor_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_distance <= IN_W'(2048);
            r_cfg.linear_gain   <= GN_W'(256);
            r_cfg.angular_gain  <= GN_W'(1024);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STOP_DIST: r_cfg.stop_distance <= i_cfg_data;
                CFG_LIN_GAIN:  r_cfg.linear_gain   <= i_cfg_data[GN_W-1:0];
                CFG_ANG_GAIN:  r_cfg.angular_gain  <= i_cfg_data[GN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held by the receiver
    assign w_en    = !w_out_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = w_out_valid;

    pshc_prep u_prep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_en),
        .i_valid            (i_valid),
        .i_leader_x         (i_leader_x),
        .i_leader_y         (i_leader_y),
        .i_follower_x       (i_follower_x),
        .i_follower_y       (i_follower_y),
        .i_follower_heading (i_follower_heading),
        .o_vec              (w_prep_vec),
        .o_tag              (w_prep_tag)
    );

    pshc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vec   (w_prep_vec),
        .i_tag   (w_prep_tag),
        .o_vec   (w_cor_vec),
        .o_tag   (w_cor_tag)
    );

    pshc_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_vec          (w_cor_vec),
        .i_tag          (w_cor_tag),
        .i_cfg          (r_cfg),
        .o_valid        (w_out_valid),
        .o_linear_speed (o_linear_speed),
        .o_angular_rate (o_angular_rate)
    );

endmodule
`default_nettype wire

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pshc_pkg::*;

    localparam int LATENCY        = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POS_MAX        = 49151;
    localparam int HD_MAX         = 12868;
    localparam int ITEMS_PER_PHASE = 220;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

    // fixed-point constants of the control law, angles in q.16
    localparam longint PI_Q16     = 205887;
    localparam longint TWO_PI_Q16 = 411775;
    localparam longint INV_K_Q16  = 39797;
    localparam longint ROUND_Q20  = 524288;
    localparam longint LIN_SAT    = 262143;
    localparam longint ANG_HI     = 262143;
    localparam longint ANG_LO     = -262144;
    localparam int     ARCTAN_LEN = 20;
    localparam longint ARCTAN_Q16 [ARCTAN_LEN] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
        64, 32, 16, 8, 4, 2, 1, 0, 0, 0
    };

    typedef struct {
        logic [IN_W-1:0]        lx;
        logic [IN_W-1:0]        ly;
        logic [IN_W-1:0]        fx;
        logic [IN_W-1:0]        fy;
        logic signed [HD_W-1:0] hd;
    } t_pose;

    typedef struct {
        logic [LIN_W-1:0]        lin;
        logic signed [ANG_W-1:0] ang;
    } t_command;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALLS} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [IN_W-1:0]        i_leader_x = '0;
    logic [IN_W-1:0]        i_leader_y = '0;
    logic [IN_W-1:0]        i_follower_x = '0;
    logic [IN_W-1:0]        i_follower_y = '0;
    logic signed [HD_W-1:0] i_follower_heading = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [LIN_W-1:0]       o_linear_speed;
    logic signed [ANG_W-1:0] o_angular_rate;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_idx = '0;
    logic [IN_W-1:0]        i_cfg_data = '0;

    // shadow copy of the control registers
    logic [IN_W-1:0] stop_dist_r  = 16'd2048;
    logic [GN_W-1:0] lin_gain_r   = 12'd256;
    logic [GN_W-1:0] ang_gain_r   = 12'd1024;

    t_command pending_commands [$];
    t_command exp_cmd;
    int       fail_count   = 0;
    int       burst_left   = 0;
    int       quiet_cycles = 0;
    t_rx_mode ready_mode   = RX_ALWAYS;
    int       mode_left    = 0;
    int       stall_left   = 0;
    int       rx_phase     = 0;

    pursuit_speed_heading_control_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_leader_x         (i_leader_x),
        .i_leader_y         (i_leader_y),
        .i_follower_x       (i_follower_x),
        .i_follower_y       (i_follower_y),
        .i_follower_heading (i_follower_heading),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_linear_speed     (o_linear_speed),
        .o_angular_rate     (o_angular_rate),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // vectoring cordic: distance in q.12 and bearing in q.16 radians
    function automatic void range_bearing(input t_pose p, output longint rng,
                                          output longint bearing);
        longint dx, dy, x, y, z, xs, ys;
        dx = longint'(p.lx) - longint'(p.fx);
        dy = longint'(p.ly) - longint'(p.fy);
        if (dx == 0 && dy == 0) begin
            rng = 0;
            bearing = 0;
            return;
        end
        x = dx * 16;
        y = dy * 16;
        z = 0;
        // left half plane: rotate by pi first
        if (x < 0) begin
            z = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ARCTAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q16[i];
            end
        end
        rng = (x * INV_K_Q16 + ROUND_Q20) >>> 20;
        if (rng < 0) rng = 0;
        bearing = z;
    endfunction

    function automatic t_command predict_command(input t_pose p);
        longint   rng, bearing, err, lin, ang;
        t_command c;
        range_bearing(p, rng, bearing);
        err = bearing - longint'(p.hd) * 16;
        // two passes cover any 15-bit heading
        repeat (2) begin
            if (err > PI_Q16) begin
                err = err - TWO_PI_Q16;
            end else if (err < -PI_Q16) begin
                err = err + TWO_PI_Q16;
            end
        end
        if (rng > longint'(stop_dist_r)) begin
            lin = (rng * longint'(lin_gain_r) + 128) >>> 8;
            if (lin > LIN_SAT) lin = LIN_SAT;
        end else begin
            lin = 0;
        end
        ang = (err * longint'(ang_gain_r) + 2048) >>> 12;
        if (ang > ANG_HI) ang = ANG_HI;
        if (ang < ANG_LO) ang = ANG_LO;
        c.lin = lin[LIN_W-1:0];
        c.ang = ang[ANG_W-1:0];
        return c;
    endfunction

    function automatic t_pose make_pose(input int lx, input int ly, input int fx,
                                        input int fy, input int hd);
        t_pose p;
        p.lx = IN_W'(lx);
        p.ly = IN_W'(ly);
        p.fx = IN_W'(fx);
        p.fy = IN_W'(fy);
        p.hd = HD_W'(hd);
        return p;
    endfunction

    function automatic t_pose random_pose();
        int kind, lx, ly, fx, fy, hd;
        kind = $urandom_range(0, 9);
        lx = $urandom_range(0, POS_MAX);
        ly = $urandom_range(0, POS_MAX);
        fx = $urandom_range(0, POS_MAX);
        fy = $urandom_range(0, POS_MAX);
        if (kind == 6 || kind == 7) begin
            // follower close to the leader, around the stop distance
            fx = lx + int'($urandom_range(0, 8192)) - 4096;
            fy = ly + int'($urandom_range(0, 8192)) - 4096;
            fx = (fx < 0) ? 0 : ((fx > POS_MAX) ? POS_MAX : fx);
            fy = (fy < 0) ? 0 : ((fy > POS_MAX) ? POS_MAX : fy);
        end else if (kind == 8) begin
            if ($urandom_range(0, 1) == 0) fx = lx;
            else fy = ly;
        end else if (kind == 9) begin
            fx = lx;
            fy = ly;
        end
        if ($urandom_range(0, 19) == 0) begin
            hd = $urandom;
        end else begin
            hd = int'($urandom_range(0, 2 * HD_MAX)) - HD_MAX;
        end
        return make_pose(lx, ly, fx, fy, hd);
    endfunction

    task automatic send_pose(input t_pose p);
        i_leader_x         <= p.lx;
        i_leader_y         <= p.ly;
        i_follower_x       <= p.fx;
        i_follower_y       <= p.fy;
        i_follower_heading <= p.hd;
        i_valid            <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_commands.push_back(predict_command(p));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 24);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_registers(input int stop, input int lg, input int ag,
                                 input bit touch_spare);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STOP_DIST;
        i_cfg_data <= IN_W'(stop);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIN_GAIN;
        i_cfg_data <= IN_W'(lg);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ANG_GAIN;
        i_cfg_data <= IN_W'(ag);
        @(posedge i_clk);
        if (touch_spare) begin
            // unused index must leave every register alone
            i_cfg_idx  <= CFG_SPARE_IDX;
            i_cfg_data <= IN_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        stop_dist_r = IN_W'(stop);
        lin_gain_r  = GN_W'(lg);
        ang_gain_r  = GN_W'(ag);
    endtask

    task automatic test_directed();
        send_pose(make_pose(12345, 23456, 12345, 23456, 0));
        send_pose(make_pose(12345, 23456, 12345, 23456, HD_MAX));
        send_pose(make_pose(POS_MAX, 0, 0, 0, 0));
        send_pose(make_pose(0, 100, POS_MAX, 100, -HD_MAX));
        send_pose(make_pose(0, POS_MAX, POS_MAX, 0, HD_MAX));
        send_pose(make_pose(0, 0, POS_MAX, POS_MAX, -HD_MAX));
        send_pose(make_pose(1000, 40000, 1000, 0, 0));
        send_pose(make_pose(1000, 0, 1000, 40000, -16384));
        send_pose(make_pose(40000, 0, 0, 40000, 16383));
        send_pose(make_pose(POS_MAX, POS_MAX, 0, 0, -HD_MAX));
        send_pose(make_pose(20001, 5000, 20000, 5000, 0));
        send_pose(make_pose(20000, 5000, 20001, 5000, -1));
        send_pose(make_pose(20000, 5001, 20000, 5000, 16383));
        send_pose(make_pose(0, POS_MAX, POS_MAX, POS_MAX, -16384));
        send_pose(make_pose(POS_MAX, 0, POS_MAX, POS_MAX, 1));
        send_pose(make_pose(24000, 24100, 24000, 24000, HD_MAX));
    endtask

    task automatic test_threshold();
        t_pose  p;
        longint rng, bearing;
        p = make_pose(30000, 20000, 10000, 5000, 1000);
        range_bearing(p, rng, bearing);
        // distance equal to the threshold gives no speed
        set_registers(int'(rng), 256, 1024, 1'b0);
        send_pose(p);
        set_registers(int'(rng) - 1, 256, 1024, 1'b0);
        send_pose(p);
        set_registers(int'(rng) + 1, 256, 1024, 1'b0);
        send_pose(p);
        set_registers(0, 256, 1024, 1'b0);
        send_pose(make_pose(777, 888, 777, 888, 0));
        send_pose(make_pose(778, 888, 777, 888, 0));
    endtask

    task automatic test_gain_extremes();
        set_registers(0, 4095, 4095, 1'b0);
        send_pose(make_pose(POS_MAX, POS_MAX, 0, 0, -HD_MAX));
        send_pose(make_pose(0, 0, POS_MAX, POS_MAX, HD_MAX));
        send_pose(make_pose(0, 100, POS_MAX, 100, -HD_MAX));
        repeat (10) send_pose(random_pose());
        set_registers(16'hFFFF, 0, 0, 1'b0);
        send_pose(make_pose(POS_MAX, POS_MAX, 0, 0, -HD_MAX));
        repeat (10) send_pose(random_pose());
        set_registers(2048, 256, 1024, 1'b1);
        repeat (10) send_pose(random_pose());
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_registers($urandom, $urandom, $urandom, 1'b0);
                1: set_registers(0, 4095, 4095, 1'b0);
                2: set_registers($urandom_range(0, 4096), $urandom, $urandom, 1'b0);
                3: set_registers(16'hFFFF, 1, 1, 1'b0);
                default: set_registers(2048, 256, 1024, 1'b1);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender holds off until the pipeline has emptied
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) wait_drained();
                send_pose(random_pose());
            end
        end
    endtask

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_commands.size() == 0) begin
                    $error("result transaction with no command pending");
                    fail_count++;
                end else begin
                    exp_cmd = pending_commands.pop_front();
                    if (o_linear_speed !== exp_cmd.lin) begin
                        $error("linear_speed: expected %0d, got %0d",
                               exp_cmd.lin, o_linear_speed);
                        fail_count++;
                    end
                    if (o_angular_rate !== exp_cmd.ang) begin
                        $error("angular_rate: expected %0d, got %0d",
                               exp_cmd.ang, o_angular_rate);
                        fail_count++;
                    end
                end
            end
            rx_phase++;
            if (mode_left == 0) begin
                ready_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RX_ALWAYS:   i_ready <= 1'b1;
                    RX_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_ready <= ((rx_phase % 7) >= 3);
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(4, 30);
                            i_ready <= 1'b0;
                        end else begin
                            i_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_threshold();
        test_gain_extremes();
        test_random_traffic();
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0 && pending_commands.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
